[hw/rtl/fsmf_pkg.sv]
// shared types and register codes for the first substring match finder
`timescale 1ns / 1ps

package fsmf_pkg;

  // widest pattern the register file can hold
  localparam int unsigned PATTERN_BYTES = 16;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_PATTERN_LENGTH = 2'd0,
    REG_PATTERN_LOW    = 2'd1,
    REG_PATTERN_HIGH   = 2'd2
  } reg_index_t;

  // one text transaction
  typedef struct packed {
    logic [7:0] text_byte;
    logic       byte_valid;
    logic       last_byte;
  } text_t;

  // one result transaction
  typedef struct packed {
    logic        found;
    logic [15:0] match_position;
    logic        overflow;
  } result_t;

  // pattern bytes, byte 0 in the low bits
  typedef logic [PATTERN_BYTES-1:0][7:0] pattern_t;

endpackage

[hw/rtl/fsmf_cell.sv]
// one window cell: holds a recent text byte and compares it to its pattern byte
`timescale 1ns / 1ps

module fsmf_cell #(
  parameter int unsigned POS = 0
) (
  input  logic              clk,
  input  logic              shift,
  input  logic [7:0]        byte_in,
  input  logic [4:0]        length,
  input  fsmf_pkg::pattern_t pattern,
  output logic [7:0]        byte_out,
  output logic              hit
);

  logic [7:0] held;
  logic       used;
  logic [3:0] sel;

  // shift register stage, fed by the newer neighbor
  always_ff @(posedge clk) begin
    if (shift) begin
      held <= byte_in;
    end
  end

  // this cell holds the byte that lines up with pattern byte length-2-POS
  assign used = (6'(POS) + 6'd2) <= {1'b0, length};
  assign sel  = 4'(length - 5'(POS) - 5'd2);
  assign hit  = !used || (held == pattern[sel]);

  assign byte_out = held;

endmodule

[hw/rtl/fsmf_out_buf.sv]
// two-entry result buffer: output register plus skid stage
`timescale 1ns / 1ps

module fsmf_out_buf (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  fsmf_pkg::result_t push_data,
  output logic              full,
  output logic              result_valid,
  input  logic              result_stall,
  output fsmf_pkg::result_t result
);

  logic              skid_valid;
  fsmf_pkg::result_t skid;
  logic              take;

  assign take = result_valid && !result_stall;
  assign full = skid_valid;

  // valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (skid_valid) begin
      if (take) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!result_valid || take) begin
        result_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (take) begin
      result_valid <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (take) begin
        result <= skid;
      end
    end else if (push) begin
      if (!result_valid || take) begin
        result <= push_data;
      end else begin
        skid <= push_data;
      end
    end
  end

`ifndef SYNTH
  // a held skid entry always sits behind a waiting output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> result_valid)
    else $error("skid entry without output entry");

  // an output left waiting keeps its transaction
  a_out_holds: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> (result_valid && $stable(result)))
    else $error("stalled result changed");

  // nothing is pushed while both entries are taken
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("push into full buffer");
`endif

endmodule

[hw/rtl/first_substring_match_finder_core.sv]
// streaming first-occurrence substring search over a chain of window cells
// the result of the transaction marked last_byte is registered in the result buffer
// throughput: one text transaction per cycle while text_stall is low; the window compare across
//   the cell chain is combinational and the byte counter is registered on each accepted byte
// a two-entry result buffer keeps text flowing while a result waits
// reset: synchronous, clears the byte counter, match state and all configuration registers
`timescale 1ns / 1ps

module first_substring_match_finder_core #(
  parameter int unsigned PATTERN_MAX = 16,
  parameter int unsigned TEXT_MAX    = 65536
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [1:0]        cfg_index,
  input  logic [63:0]       cfg_data,
  input  logic              text_valid,
  output logic              text_stall,
  input  fsmf_pkg::text_t   text,
  output logic              result_valid,
  input  logic              result_stall,
  output fsmf_pkg::result_t result
);

  localparam int unsigned NCELL = PATTERN_MAX - 1;
  localparam int unsigned CW    = $clog2(TEXT_MAX + 1);

  // configuration
  logic [4:0]  pattern_length;
  logic [63:0] pattern_low;
  logic [63:0] pattern_high;

  // text state
  logic [CW-1:0] byte_count;
  logic          match_seen;
  logic [15:0]   first_match_pos;
  logic          count_overflow;

  logic [CW-1:0] byte_count_next;
  logic          match_seen_next;
  logic [15:0]   first_match_pos_next;
  logic          count_overflow_next;

  fsmf_pkg::pattern_t pattern;
  logic [4:0]         length;
  logic [CW-1:0]      length_ext;
  logic               accept;
  logic               room;
  logic               take;
  logic               hit;
  logic               push;
  fsmf_pkg::result_t  push_data;

  logic [NCELL-1:0][7:0] window;
  logic [NCELL-1:0]      cell_hit;

  assign pattern    = {pattern_high, pattern_low};
  assign length     = (pattern_length > 5'(PATTERN_MAX)) ? 5'(PATTERN_MAX) : pattern_length;
  assign length_ext = CW'(length);

  assign accept = text_valid && !text_stall;
  assign room   = byte_count < CW'(TEXT_MAX);
  assign take   = accept && text.byte_valid && room;

  // window cells, cell 0 holds the newest byte
  for (genvar j = 0; j < NCELL; j++) begin : g_cell
    fsmf_cell #(
      .POS(j)
    ) u_cell (
      .clk     (clk),
      .shift   (take),
      .byte_in ((j == 0) ? text.text_byte : window[(j == 0) ? 0 : j - 1]),
      .length  (length),
      .pattern (pattern),
      .byte_out(window[j]),
      .hit     (cell_hit[j])
    );
  end

  // full window compare for the incoming byte
  assign hit = (length != 5'd0) && (byte_count >= length_ext - CW'(1)) && !match_seen
            && (text.text_byte == pattern[4'(length - 5'd1)]) && (&cell_hit);

  // text state after this transaction
  always_comb begin
    byte_count_next      = byte_count;
    match_seen_next      = match_seen;
    first_match_pos_next = first_match_pos;
    count_overflow_next  = count_overflow;
    if (text.byte_valid) begin
      if (room) begin
        byte_count_next = byte_count + CW'(1);
        if (hit) begin
          match_seen_next      = 1'b1;
          first_match_pos_next = 16'(byte_count + CW'(1) - length_ext);
        end
      end else begin
        count_overflow_next = 1'b1;
      end
    end
  end

  // result for a closing transaction
  always_comb begin
    push_data.overflow = count_overflow_next;
    if (length == 5'd0) begin
      push_data.found          = 1'b1;
      push_data.match_position = 16'd0;
    end else if (match_seen_next) begin
      push_data.found          = 1'b1;
      push_data.match_position = first_match_pos_next;
    end else begin
      push_data.found          = 1'b0;
      push_data.match_position = 16'd0;
    end
  end

  assign push = accept && text.last_byte;

  // configuration and text state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length  <= 5'd0;
      pattern_low     <= 64'd0;
      pattern_high    <= 64'd0;
      byte_count      <= '0;
      match_seen      <= 1'b0;
      first_match_pos <= 16'd0;
      count_overflow  <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          fsmf_pkg::REG_PATTERN_LENGTH: pattern_length <= cfg_data[4:0];
          fsmf_pkg::REG_PATTERN_LOW:    pattern_low    <= cfg_data;
          fsmf_pkg::REG_PATTERN_HIGH:   pattern_high   <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        if (text.last_byte) begin
          byte_count      <= '0;
          match_seen      <= 1'b0;
          first_match_pos <= 16'd0;
          count_overflow  <= 1'b0;
        end else begin
          byte_count      <= byte_count_next;
          match_seen      <= match_seen_next;
          first_match_pos <= first_match_pos_next;
          count_overflow  <= count_overflow_next;
        end
      end
    end
  end

  // result buffer
  fsmf_out_buf u_out_buf (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .push_data   (push_data),
    .full        (text_stall),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result)
  );

`ifndef SYNTH
  // the byte counter saturates at the text limit
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    byte_count <= CW'(TEXT_MAX))
    else $error("byte counter past limit");

  // a closing transaction leaves a clean text state
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    (accept && text.last_byte) |=> (byte_count == '0 && !match_seen && !count_overflow))
    else $error("text state not cleared");

  // a match is recorded only by an accepted byte inside the limit
  a_match_from_byte: assert property (@(posedge clk) disable iff (rst)
    (!match_seen ##1 match_seen) |-> $past(take))
    else $error("match recorded without a byte");

  // overflow is only flagged once the counter has saturated
  a_overflow_saturated: assert property (@(posedge clk) disable iff (rst)
    count_overflow |-> (byte_count == CW'(TEXT_MAX)))
    else $error("overflow before counter saturated");
`endif

endmodule

[test/first_substring_match_finder_core_tb.sv]
// testbench for the first substring match finder core
`timescale 1ns / 1ps

module first_substring_match_finder_core_tb;

  localparam int unsigned PATTERN_LIMIT = 16;
  localparam int unsigned TEXT_LIMIT    = 65536;
  localparam int unsigned RANDOM_ITEMS  = 1250;
  localparam int unsigned CYCLE_LIMIT   = 2_000_000;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned MAX_REPORTS   = 10;

  // clock, reset and block ports
  logic              clk          = 1'b0;
  logic              rst          = 1'b1;
  logic              cfg_write    = 1'b0;
  logic [1:0]        cfg_index    = fsmf_pkg::REG_PATTERN_LENGTH;
  logic [63:0]       cfg_data     = '0;
  logic              text_valid   = 1'b0;
  logic              text_stall;
  fsmf_pkg::text_t   text         = '0;
  logic              result_valid;
  logic              result_stall = 1'b0;
  fsmf_pkg::result_t result;

  // search state mirrored from the block
  logic [4:0]  length_reg  = '0;
  logic [63:0] pattern_lo  = '0;
  logic [63:0] pattern_hi  = '0;
  logic [7:0]  window_bytes [PATTERN_LIMIT-1];
  int unsigned bytes_seen;
  bit          match_found;
  logic [15:0] match_start;
  bit          text_overflow;

  fsmf_pkg::result_t pending_search_results [$];
  int unsigned error_count = 0;
  int unsigned cycle_count;
  int unsigned stall_left  = 0;
  bit          no_gaps     = 1'b0;

  first_substring_match_finder_core #(
    .PATTERN_MAX(PATTERN_LIMIT),
    .TEXT_MAX   (TEXT_LIMIT)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .text_valid  (text_valid),
    .text_stall  (text_stall),
    .text        (text),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // pattern length in use, clamped to the window size
  function automatic int unsigned active_len();
    return (length_reg > PATTERN_LIMIT) ? PATTERN_LIMIT : int'(length_reg);
  endfunction

  function automatic logic [7:0] pattern_at(int unsigned k);
    return (k < 8) ? pattern_lo[8*k +: 8] : pattern_hi[8*(k-8) +: 8];
  endfunction

  function automatic void clear_text();
    foreach (window_bytes[i]) window_bytes[i] = '0;
    bytes_seen    = 0;
    match_found   = 1'b0;
    match_start   = '0;
    text_overflow = 1'b0;
  endfunction

  // advance the search by one accepted transaction, queue the verdict on the last one
  function automatic void advance_search(fsmf_pkg::text_t item);
    int unsigned       len;
    bit                hit;
    fsmf_pkg::result_t verdict;
    len = active_len();
    if (item.byte_valid) begin
      if (bytes_seen < TEXT_LIMIT) begin
        if (len > 0 && bytes_seen + 1 >= len && !match_found) begin
          hit = (pattern_at(len - 1) == item.text_byte);
          for (int unsigned k = 0; k + 1 < len; k++)
            if (window_bytes[len - 2 - k] != pattern_at(k)) hit = 1'b0;
          if (hit) begin
            match_found = 1'b1;
            match_start = 16'(bytes_seen + 1 - len);
          end
        end
        for (int j = PATTERN_LIMIT - 2; j > 0; j--) window_bytes[j] = window_bytes[j-1];
        window_bytes[0] = item.text_byte;
        bytes_seen++;
      end else begin
        text_overflow = 1'b1;
      end
    end
    if (item.last_byte) begin
      verdict.found          = (len == 0) || match_found;
      verdict.match_position = (len != 0 && match_found) ? match_start : '0;
      verdict.overflow       = text_overflow;
      pending_search_results.push_back(verdict);
      clear_text();
    end
  endfunction

  // idle lengths: mostly short, a few long
  function automatic int unsigned idle_span();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 8);
    return $urandom_range(12, 30);
  endfunction

  function automatic int unsigned sender_gap();
    if (no_gaps || $urandom_range(0, 99) < 50) return 0;
    return idle_span();
  endfunction

  task automatic note_mismatch(string what);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("mismatch: %s", what);
  endtask

  // send one text transaction and track it once accepted
  task automatic send_text(fsmf_pkg::text_t item);
    int unsigned gap;
    gap = sender_gap();
    if (gap != 0) begin
      text_valid <= 1'b0;
      text       <= fsmf_pkg::text_t'(10'($urandom));
      repeat (gap) @(posedge clk);
    end
    text_valid <= 1'b1;
    text       <= item;
    do @(posedge clk); while (text_stall);
    advance_search(item);
  endtask

  task automatic push_text(logic [7:0] value, bit valid, bit last);
    fsmf_pkg::text_t item;
    item.text_byte  = value;
    item.byte_valid = valid;
    item.last_byte  = last;
    send_text(item);
  endtask

  // whole text, ended on the final byte or by a separate end marker
  task automatic send_text_bytes(logic [7:0] bytes [$], bit separate_end, bit noisy);
    for (int i = 0; i < bytes.size(); i++) begin
      if (noisy && $urandom_range(0, 19) == 0) push_text(8'($urandom), 1'b0, 1'b0);
      push_text(bytes[i], 1'b1, !separate_end && i == bytes.size() - 1);
    end
    if (separate_end || bytes.size() == 0) push_text(8'($urandom), 1'b0, 1'b1);
  endtask

  // let every result drain before touching the registers
  task automatic wait_idle();
    text_valid <= 1'b0;
    while (pending_search_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write all three registers, junk above the length field
  task automatic configure(logic [4:0] len, logic [63:0] lo, logic [63:0] hi);
    cfg_write <= 1'b1;
    cfg_index <= fsmf_pkg::REG_PATTERN_LENGTH;
    cfg_data  <= {$urandom, 27'($urandom), len};
    @(posedge clk);
    cfg_index <= fsmf_pkg::REG_PATTERN_LOW;
    cfg_data  <= lo;
    @(posedge clk);
    cfg_index <= fsmf_pkg::REG_PATTERN_HIGH;
    cfg_data  <= hi;
    @(posedge clk);
    cfg_write  <= 1'b0;
    length_reg = len;
    pattern_lo = lo;
    pattern_hi = hi;
  endtask

  task automatic send_filler(int unsigned count);
    repeat (count) push_text(8'($urandom_range(0, 127)), 1'b1, 1'b0);
  endtask

  task automatic send_high_pattern(bit last);
    for (int unsigned k = 0; k < PATTERN_LIMIT; k++)
      push_text(8'h80 + 8'(k), 1'b1, last && k == PATTERN_LIMIT - 1);
  endtask

  // empty pattern matches at zero, even on an empty text
  task automatic test_empty_pattern();
    wait_idle();
    configure(5'd0, '1, '1);
    push_text(8'($urandom), 1'b0, 1'b1);
    push_text(8'($urandom), 1'b0, 1'b0);
    push_text(8'hFF, 1'b1, 1'b1);
  endtask

  // zero bytes in pattern and text, pattern longer than the text
  task automatic test_zero_bytes();
    wait_idle();
    configure(5'd3, {$urandom, 8'($urandom), 24'h00FF00}, {$urandom, $urandom});
    push_text(8'h00, 1'b1, 1'b1);
    push_text(8'hFF, 1'b1, 1'b0);
    push_text(8'h00, 1'b1, 1'b0);
    push_text(8'($urandom), 1'b0, 1'b0);
    push_text(8'hFF, 1'b1, 1'b0);
    push_text(8'h00, 1'b1, 1'b1);
  endtask

  // length above the window size is clamped to a full window
  task automatic test_length_clamp();
    wait_idle();
    configure(5'd31, 64'h0706050403020100, 64'h0F0E0D0C0B0A0908);
    for (int unsigned k = 0; k < PATTERN_LIMIT; k++)
      push_text(8'(k), 1'b1, k == PATTERN_LIMIT - 1);
  endtask

  // counter saturation: exact fill, late match ignored, early match kept
  task automatic test_text_limit();
    no_gaps = 1'b1;
    wait_idle();
    configure(5'd16, 64'h8786858483828180, 64'h8F8E8D8C8B8A8988);
    send_filler(TEXT_LIMIT - PATTERN_LIMIT);
    send_high_pattern(1'b1);
    send_filler(TEXT_LIMIT);
    send_high_pattern(1'b1);
    send_filler(5);
    send_high_pattern(1'b0);
    send_filler(TEXT_LIMIT);
    push_text(8'($urandom), 1'b0, 1'b1);
    no_gaps = 1'b0;
  endtask

  // random texts over a small alphabet with planted and broken pattern copies
  task automatic test_random_texts();
    int unsigned sent;
    int unsigned text_no;
    int unsigned len;
    int unsigned at;
    int unsigned cut;
    int unsigned r;
    logic [7:0]  alphabet [4];
    logic [7:0]  body [$];
    logic [63:0] lo;
    logic [63:0] hi;
    bit          separate_end;
    sent    = 0;
    text_no = 0;
    while (sent < RANDOM_ITEMS) begin
      // new pattern every few texts
      if (text_no % 6 == 0) begin
        wait_idle();
        foreach (alphabet[i]) alphabet[i] = 8'($urandom);
        if ($urandom_range(0, 1)) alphabet[0] = 8'h00;
        if ($urandom_range(0, 2) == 0) alphabet[1] = 8'hFF;
        for (int unsigned b = 0; b < 8; b++) begin
          lo[8*b +: 8] = alphabet[$urandom_range(0, 3)];
          hi[8*b +: 8] = alphabet[$urandom_range(0, 3)];
        end
        if ($urandom_range(0, 9) == 0) begin
          lo = {$urandom, $urandom};
          hi = {$urandom, $urandom};
        end
        r = $urandom_range(0, 99);
        if (r < 10)      len = 0;
        else if (r < 20) len = 16;
        else if (r < 27) len = $urandom_range(17, 31);
        else if (r < 45) len = $urandom_range(7, 15);
        else             len = $urandom_range(1, 6);
        configure(5'(len), lo, hi);
      end
      no_gaps = (text_no % 10 >= 8);
      // text body
      len = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 20) : $urandom_range(21, 48);
      body.delete();
      repeat (len)
        body.push_back(($urandom_range(0, 99) < 80) ? alphabet[$urandom_range(0, 3)]
                                                    : 8'($urandom));
      repeat ($urandom_range(0, 2)) begin
        at  = $urandom_range(0, body.size());
        cut = ($urandom_range(0, 3) == 0) ? 1 : 0;
        for (int k = int'(active_len()) - 1 - int'(cut); k >= 0; k--)
          body.insert(at, pattern_at(k));
      end
      separate_end = $urandom_range(0, 1);
      send_text_bytes(body, separate_end, 1'b1);
      sent += body.size() + ((separate_end || body.size() == 0) ? 1 : 0);
      text_no++;
    end
    no_gaps = 1'b0;
  endtask

  // random result stalls
  always @(posedge clk) begin : drive_result_stall
    if (stall_left != 0) begin
      result_stall <= 1'b1;
      stall_left   <= stall_left - 1;
    end else if (!no_gaps && $urandom_range(0, 99) < 25) begin
      result_stall <= 1'b1;
      stall_left   <= idle_span() - 1;
    end else begin
      result_stall <= 1'b0;
    end
  end

  // compare each result transaction with the oldest verdict
  always @(posedge clk) begin : check_results
    fsmf_pkg::result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_search_results.size() == 0) begin
        note_mismatch($sformatf("unexpected result %p", result));
      end else begin
        want = pending_search_results.pop_front();
        if (result.found !== want.found)
          note_mismatch($sformatf("found expected %0d, got %0d", want.found, result.found));
        if (result.match_position !== want.match_position)
          note_mismatch($sformatf("match_position expected %0d, got %0d",
                                  want.match_position, result.match_position));
        if (result.overflow !== want.overflow)
          note_mismatch($sformatf("overflow expected %0d, got %0d",
                                  want.overflow, result.overflow));
      end
    end
  end

  // run limit
  initial begin : watchdog
    for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clk);
    $display("[first_substring_match_finder_core] ERROR");
    $finish;
  end

  // test sequence
  initial begin
    clear_text();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_empty_pattern();
    test_zero_bytes();
    test_length_clamp();
    test_random_texts();
    test_text_limit();
    wait_idle();
    if (error_count == 0 && pending_search_results.size() == 0) begin
      $display("[first_substring_match_finder_core] OK");
    end else begin
      $display("[first_substring_match_finder_core] ERROR");
    end
    $finish;
  end

endmodule
